/* rtl/core/ss_pkg.sv */
// Shared payload types and constants for the stooge sorter.
`timescale 1ns / 1ps

package ss_pkg;

    // One input item: a signed element and the end-of-set marker
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } in_item_t;

    // One result item: a sorted element with its set flags
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_res;
        logic               overflow;
    } out_item_t;

    // Division by three as (len * 171) >> 9, exact for len below 384
    localparam int unsigned THIRD_MUL   = 171;
    localparam int unsigned THIRD_MUL_W = 8;
    localparam int unsigned THIRD_SHIFT = 9;

    // Number of sub-ranges visited per range before it is popped
    localparam logic [1:0] PHASE_DONE = 2'd3;

endpackage

/* rtl/core/stooge_sorter.sv */
// Stooge sorter top level: element store, range stack and sort sequencer.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one signed 32-bit element per
//   item; s_data.last closes the set. Up to DEPTH elements are kept, later
//   items of the same set are dropped and every result of that set then shows
//   overflow = 1. s_ready is high only while the block collects a set.
//   After the closing item the set is sorted in place by stooge sort, one
//   compare-and-swap at a time through a single comparator and a two-read,
//   one-write element memory, with the recursion on a STACK_DEPTH-entry stack.
//   Each range goes through read (ST_OPEN), compare (ST_CMP), a second
//   write when its ends are swapped (ST_SWAP2) and a sequencer step
//   (ST_STEP); every pushed range takes one more step to pop. For n = 32
//   that is 9841 ranges (about n^2.71 ranges). Results then leave, each read
//   only after the previous one is taken, on m_valid/m_ready/m_data in
//   ascending order; m_data.final_res marks the last one. A stalled receiver
//   holds m_valid and m_data unchanged and the block simply waits. After the
//   final result is taken the block returns to collecting a new set.
//   Reset (aresetn low, synchronous) empties the set, clears the overflow
//   flag and the stack, and leaves the block ready for input.
`timescale 1ns / 1ps

module stooge_sorter #(
    parameter int DEPTH       = 32,
    parameter int STACK_DEPTH = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ss_pkg::in_item_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ss_pkg::out_item_t m_data
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LW  = AW + 1;
    localparam int PW  = LW + ss_pkg::THIRD_MUL_W;
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_OPEN,
        ST_CMP,
        ST_SWAP2,
        ST_STEP,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_HOLD
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [AW-1:0]     s_reg, s_next;
    logic [AW-1:0]     e_reg, e_next;
    logic [AW-1:0]     k_reg, k_next;
    logic              m_valid_reg, m_valid_next;
    ss_pkg::out_item_t m_data_reg, m_data_next;

    // Element memory and its registered read ports
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd0_reg, rd1_reg;
    logic [AW-1:0]      rd_addr0;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;

    // Range stack
    logic [AW-1:0] stk_start_reg [STACK_DEPTH];
    logic [AW-1:0] stk_end_reg   [STACK_DEPTH];
    logic [1:0]    stk_phase_reg [STACK_DEPTH];
    logic          stk_push;
    logic          stk_adv;

    logic [SPW-1:0] sp_dec;
    logic [SIW-1:0] top_idx;
    logic [SIW-1:0] push_idx;
    logic [AW-1:0]  top_s, top_e;
    logic [1:0]     top_ph;
    logic [LW-1:0]  top_len, cur_len;
    logic [PW-1:0]  third_prod;
    logic [AW-1:0]  third;
    logic [CW-1:0]  n_load;
    logic [CW-1:0]  k_plus1;
    logic           room;
    logic           s_fire;
    logic           m_fire;
    logic           gt;
    logic           is_final;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid_reg && m_ready;

    // Top-of-stack view and one-third split of the top range
    assign sp_dec     = sp_reg - SPW'(1);
    assign top_idx    = sp_dec[SIW-1:0];
    assign push_idx   = sp_reg[SIW-1:0];
    assign top_s      = stk_start_reg[top_idx];
    assign top_e      = stk_end_reg[top_idx];
    assign top_ph     = stk_phase_reg[top_idx];
    assign top_len    = LW'(top_e) - LW'(top_s) + LW'(1);
    assign third_prod = PW'(top_len) * PW'(ss_pkg::THIRD_MUL);
    assign third      = AW'(third_prod >> ss_pkg::THIRD_SHIFT);

    assign cur_len  = LW'(e_reg) - LW'(s_reg) + LW'(1);
    assign gt       = (rd0_reg > rd1_reg);
    assign room     = (count_reg < CW'(DEPTH));
    assign n_load   = room ? (count_reg + CW'(1)) : count_reg;
    assign k_plus1  = CW'(k_reg) + CW'(1);
    assign is_final = (k_plus1 == count_reg);
    assign rd_addr0 = (state_reg == ST_OUT_RD) ? k_reg : s_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        sp_next      = sp_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = s_reg;
        mem_wdata    = rd1_reg;
        stk_push     = 1'b0;
        stk_adv      = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    count_next = n_load;
                    if (room) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_reg[AW-1:0];
                        mem_wdata = s_data.value;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_data.last) begin
                        sp_next = '0;
                        k_next  = '0;
                        if (n_load > CW'(1)) begin
                            s_next     = '0;
                            e_next     = AW'(n_load - CW'(1));
                            state_next = ST_OPEN;
                        end else begin
                            state_next = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_OPEN: begin
                // read ends of the range
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (gt) begin
                    mem_we     = 1'b1;
                    mem_waddr  = s_reg;
                    mem_wdata  = rd1_reg;
                    state_next = ST_SWAP2;
                end else begin
                    if (cur_len > LW'(2) && sp_reg < SPW'(STACK_DEPTH)) begin
                        stk_push = 1'b1;
                        sp_next  = sp_reg + SPW'(1);
                    end
                    state_next = ST_STEP;
                end
            end
            ST_SWAP2: begin
                mem_we    = 1'b1;
                mem_waddr = e_reg;
                mem_wdata = rd0_reg;
                if (cur_len > LW'(2) && sp_reg < SPW'(STACK_DEPTH)) begin
                    stk_push = 1'b1;
                    sp_next  = sp_reg + SPW'(1);
                end
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (sp_reg == '0) begin
                    k_next     = '0;
                    state_next = ST_OUT_RD;
                end else if (top_ph == ss_pkg::PHASE_DONE) begin
                    sp_next = sp_dec;
                end else begin
                    stk_adv = 1'b1;
                    if (top_ph == 2'd1) begin
                        s_next = top_s + third;
                        e_next = top_e;
                    end else begin
                        s_next = top_s;
                        e_next = top_e - third;
                    end
                    state_next = ST_OPEN;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                m_data_next.sorted_value = rd0_reg;
                m_data_next.final_res    = is_final;
                m_data_next.overflow     = dropped_reg;
                m_valid_next             = 1'b1;
                state_next               = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (m_fire) begin
                    m_valid_next = 1'b0;
                    if (m_data_reg.final_res) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        sp_next      = '0;
                        state_next   = ST_LOAD;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            sp_reg      <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            sp_reg      <= sp_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
        s_reg      <= s_next;
        e_reg      <= e_next;
        m_data_reg <= m_data_next;
    end

    // Element memory: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd0_reg <= mem[rd_addr0];
        rd1_reg <= mem[e_reg];
    end

    // Range stack writes
    always_ff @(posedge aclk) begin
        if (stk_push) begin
            stk_start_reg[push_idx] <= s_reg;
            stk_end_reg[push_idx]   <= e_reg;
            stk_phase_reg[push_idx] <= '0;
        end else if (stk_adv) begin
            stk_phase_reg[top_idx] <= top_ph + 2'd1;
        end
    end

endmodule

/* rtl/core/ss_checker.sv */
// Port-level checker for the stooge sorter, bound to the top level.
`timescale 1ns / 1ps

module ss_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input ss_pkg::in_item_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input ss_pkg::out_item_t m_data
);

    // Collecting and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // A closing item stops intake
    a_close_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last) |=> !s_ready)
        else $error("input still ready after the closing item");

    // The final result reopens intake
    a_final_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.final_res) |=> (s_ready && !m_valid))
        else $error("block not collecting after the final result");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

endmodule

bind stooge_sorter ss_checker u_ss_checker (.*);

/* bench/tb_stooge_sorter.sv */
// Self-checking testbench for stooge_sorter: directed and random sets against a stooge sort predictor.
`timescale 1ns / 1ps

module tb_stooge_sorter;

    localparam int DEPTH        = 32;
    localparam int STACK_DEPTH  = 12;
    localparam int RANDOM_ITEMS = 247;
    localparam int TAIL_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 4_000_000;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    // How element values of one random set are drawn
    typedef enum int {
        VALS_WIDE,
        VALS_NARROW,
        VALS_EDGY
    } value_mode_t;

    // Predictor and queue of sorted elements still owed by the block
    class stooge_tracker;
        logic signed [31:0] held [DEPTH];
        int unsigned        held_count = 0;
        bit                 dropped    = 1'b0;
        int unsigned        rng_start [STACK_DEPTH];
        int unsigned        rng_end   [STACK_DEPTH];
        logic [1:0]         rng_phase [STACK_DEPTH];
        int unsigned        depth_used = 0;
        ss_pkg::out_item_t  pending [$];
        int                 errors = 0;

        // End swap of [s, e]; ranges longer than two go on the stack while it has room
        function void open_range(int unsigned s, int unsigned e);
            logic signed [31:0] t;
            if (s >= e || e >= DEPTH) return;
            if (held[s] > held[e]) begin
                t       = held[s];
                held[s] = held[e];
                held[e] = t;
            end
            if (e - s + 1 > 2 && depth_used < STACK_DEPTH) begin
                rng_start[depth_used] = s;
                rng_end[depth_used]   = e;
                rng_phase[depth_used] = 2'd0;
                depth_used++;
            end
        endfunction

        // Stooge sort of the first n held elements, recursion on the range stack
        function void stooge_order(int unsigned n);
            int unsigned top, s, e, third;
            logic [1:0]  ph;
            depth_used = 0;
            if (n == 0) return;
            open_range(0, n - 1);
            while (depth_used > 0) begin
                top   = depth_used - 1;
                s     = rng_start[top];
                e     = rng_end[top];
                third = (e - s + 1) / 3;
                ph    = rng_phase[top];
                if (ph >= ss_pkg::PHASE_DONE) begin
                    depth_used = top;
                    continue;
                end
                rng_phase[top] = ph + 2'd1;
                if (ph == 2'd1)
                    open_range(s + third, e);
                else
                    open_range(s, e - third);
            end
        endfunction

        // Accepted input item: store it, and on last queue the sorted set
        function void take_element(ss_pkg::in_item_t it);
            ss_pkg::out_item_t r;
            if (held_count < DEPTH) begin
                held[held_count] = it.value;
                held_count++;
            end else begin
                dropped = 1'b1;
            end
            if (!it.last) return;
            stooge_order(held_count);
            for (int unsigned k = 0; k < held_count; k++) begin
                r.sorted_value = held[k];
                r.final_res    = (k + 1 == held_count);
                r.overflow     = dropped;
                pending.push_back(r);
            end
            held_count = 0;
            dropped    = 1'b0;
        endfunction

        // Accepted result item against the oldest owed element
        function void check_sorted(ss_pkg::out_item_t got);
            ss_pkg::out_item_t want;
            if (pending.size() == 0) begin
                $error("unexpected result item: sorted_value %0d", got.sorted_value);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
                $error("sorted_value: expected %0d, actual %0d",
                       want.sorted_value, got.sorted_value);
                errors++;
            end
            if (got.final_res !== want.final_res) begin
                $error("final_res: expected %0b, actual %0b", want.final_res, got.final_res);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ss_pkg::in_item_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ss_pkg::out_item_t m_data;

    stooge_tracker tracker = new;
    int unsigned   cycle_count = 0;

    stooge_sorter #(
        .DEPTH       (DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_value(value_mode_t mode);
        logic signed [31:0] narrow;
        narrow = int'($urandom_range(0, 6)) - 3;
        case (mode)
            VALS_WIDE:   return $urandom;
            VALS_NARROW: return narrow;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    4:       return narrow;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Offer one item after an optional gap; valid stays up for a back-to-back item
    task automatic send_item(ss_pkg::in_item_t it, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        tracker.take_element(it);
    endtask

    task automatic send_values(logic signed [31:0] vals[$]);
        ss_pkg::in_item_t it;
        foreach (vals[i]) begin
            it.value = vals[i];
            it.last  = (i == vals.size() - 1);
            send_item(it, idle_gap());
        end
    endtask

    task automatic send_random_set(int size, value_mode_t mode, bit burst);
        ss_pkg::in_item_t it;
        for (int i = 0; i < size; i++) begin
            it.value = pick_value(mode);
            it.last  = (i == size - 1);
            send_item(it, burst ? 0 : idle_gap());
        end
    endtask

    task automatic wait_drained();
        while (tracker.pending.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls with occasional long ready stretches
    initial begin
        int on_len, off_len;
        while (!aresetn) @(posedge aclk);
        forever begin
            on_len  = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 8);
            off_len = idle_gap();
            m_ready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            if (off_len > 0) begin
                m_ready <= 1'b0;
                repeat (off_len) @(posedge aclk);
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_sorted(m_data);
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Stimulus
    initial begin
        logic signed [31:0] vals[$];
        int                 set_no, sent, size, r;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single element, extremes out of order, reversed triple
        vals = '{32'sd5};
        send_values(vals);
        vals = '{VAL_MAX, VAL_MIN};
        send_values(vals);
        vals = '{32'sd3, 32'sd2, 32'sd1};
        send_values(vals);
        // Mixed extremes with duplicates
        vals = '{32'sd0, -32'sd1, VAL_MAX, 32'sd1, VAL_MIN, -32'sd1, 32'sd0};
        send_values(vals);
        // All equal
        vals = '{-32'sd2, -32'sd2, -32'sd2, -32'sd2};
        send_values(vals);
        // Already ascending
        vals = '{VAL_MIN, -32'sd100, 32'sd0, 32'sd7, 32'sd100, VAL_MAX};
        send_values(vals);

        // Random sets: first a full one, then one that overflows and closes on a dropped item
        set_no = 0;
        sent   = 0;
        while (sent < RANDOM_ITEMS) begin
            if (set_no == 0) begin
                size = DEPTH;
            end else if (set_no == 1) begin
                size = DEPTH + 2;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65)      size = $urandom_range(1, 10);
                else if (r < 88) size = $urandom_range(11, 20);
                else if (r < 95) size = $urandom_range(21, DEPTH - 1);
                else             size = $urandom_range(DEPTH, DEPTH + 4);
            end
            // Hold off now and then until the previous set is fully out
            if (set_no % 4 == 3) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            send_random_set(size, value_mode_t'($urandom_range(0, 2)),
                            $urandom_range(0, 3) == 0);
            sent += size;
            set_no++;
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* stooge_sorter.f */
rtl/core/ss_pkg.sv
rtl/core/stooge_sorter.sv
rtl/core/ss_checker.sv
bench/tb_stooge_sorter.sv
